[hw/rtl/rasi_pkg.sv]
// rasi_pkg: shared types and constants for the ray/box slab test unit
// no dependencies

package rasi_pkg;

    localparam int NUM_AXES = 3;

    typedef logic [1:0] axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    // per-item flags that travel beside the dividers
    typedef struct packed {
        logic                valid;
        logic [NUM_AXES-1:0] dir_zero;
        logic [NUM_AXES-1:0] dir_pos;
        logic                par_miss;
    } rasi_side_t;

endpackage

[hw/rtl/rasi_div.sv]
// rasi_div: pipelined restoring divider, one quotient bit per stage
// magnitude in, signed quotient out of a register behind the last stage; no package use

module rasi_div #(
    parameter int NUM_WIDTH = 49,
    parameter int DEN_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [NUM_WIDTH-1:0]        num,
    input  logic [DEN_WIDTH-1:0]        den,
    input  logic                        neg,
    output logic signed [NUM_WIDTH:0]   quo
);

    logic [DEN_WIDTH-1:0] rem_reg [NUM_WIDTH];
    logic [NUM_WIDTH-1:0] q_reg   [NUM_WIDTH];
    logic [DEN_WIDTH-1:0] den_reg [NUM_WIDTH];
    logic                 neg_reg [NUM_WIDTH];
    logic signed [NUM_WIDTH:0] quo_reg;

    genvar s;
    generate
        for (s = 0; s < NUM_WIDTH; s++) begin : g_stage
            logic [DEN_WIDTH-1:0] rem_prev;
            logic [NUM_WIDTH-1:0] q_prev;
            logic [DEN_WIDTH-1:0] den_prev;
            logic                 neg_prev;
            logic [DEN_WIDTH:0]   trial;
            logic                 fits;
            logic [DEN_WIDTH:0]   diff;
            logic [DEN_WIDTH-1:0] rem_next;
            logic [NUM_WIDTH-1:0] q_next;

            if (s == 0) begin : g_first
                assign rem_prev = '0;
                assign q_prev   = num;
                assign den_prev = den;
                assign neg_prev = neg;
            end else begin : g_rest
                assign rem_prev = rem_reg[s-1];
                assign q_prev   = q_reg[s-1];
                assign den_prev = den_reg[s-1];
                assign neg_prev = neg_reg[s-1];
            end

            always_comb
            begin
                trial    = {rem_prev, q_prev[NUM_WIDTH-1]};
                fits     = trial >= {1'b0, den_prev};
                diff     = trial - {1'b0, den_prev};
                rem_next = fits ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
                q_next   = {q_prev[NUM_WIDTH-2:0], fits};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    q_reg[s]   <= q_next;
                    den_reg[s] <= den_prev;
                    neg_reg[s] <= neg_prev;
                end
            end
        end
    endgenerate

    logic signed [NUM_WIDTH:0] quo_next;

    always_comb
    begin
        quo_next = signed'({1'b0, q_reg[NUM_WIDTH-1]});
        if (neg_reg[NUM_WIDTH-1])
            quo_next = -quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quo_reg <= '0;
        else if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

[hw/rtl/ray_aabb_slab_intersect_unit.sv]
// ray_aabb_slab_intersect_unit: ray versus axis-aligned box slab test, top level
// uses rasi_pkg and rasi_div (six pipelined dividers)
//
// channel   handshake               payload
// in        in_valid / in_ready     origin, dir, box_min, box_max (x, y, z)
// out       out_valid / out_ready   hit, t_near, normal_axis, normal_negative
//
// one item per cycle while the output is not stalled; the pipeline depth is set by the
// bit-per-stage dividers
// reset clears all valid bits and the divider quotient registers; other payload registers are not reset
// a stalled output holds the whole pipeline, in_ready follows the output register

module ray_aabb_slab_intersect_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] origin_x,
    input  logic signed [DATA_WIDTH-1:0] origin_y,
    input  logic signed [DATA_WIDTH-1:0] origin_z,
    input  logic signed [DATA_WIDTH-1:0] dir_x,
    input  logic signed [DATA_WIDTH-1:0] dir_y,
    input  logic signed [DATA_WIDTH-1:0] dir_z,
    input  logic signed [DATA_WIDTH-1:0] box_min_x,
    input  logic signed [DATA_WIDTH-1:0] box_min_y,
    input  logic signed [DATA_WIDTH-1:0] box_min_z,
    input  logic signed [DATA_WIDTH-1:0] box_max_x,
    input  logic signed [DATA_WIDTH-1:0] box_max_y,
    input  logic signed [DATA_WIDTH-1:0] box_max_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic signed [DATA_WIDTH-1:0] t_near,
    output rasi_pkg::axis_t              normal_axis,
    output logic                         normal_negative
);

    import rasi_pkg::*;

    localparam int NW  = DATA_WIDTH + FRAC_BITS + 1;
    localparam int QW  = NW + 1;
    localparam int LAT = NW + 1;
    localparam logic signed [QW-1:0] T_MAX =
        QW'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);
    localparam logic signed [QW-1:0] T_MIN = -T_MAX - QW'(1);

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: differences and axis flags
    logic signed [DATA_WIDTH-1:0] org [NUM_AXES];
    logic signed [DATA_WIDTH-1:0] dir [NUM_AXES];
    logic signed [DATA_WIDTH-1:0] bmn [NUM_AXES];
    logic signed [DATA_WIDTH-1:0] bmx [NUM_AXES];

    assign org = '{origin_x, origin_y, origin_z};
    assign dir = '{dir_x, dir_y, dir_z};
    assign bmn = '{box_min_x, box_min_y, box_min_z};
    assign bmx = '{box_max_x, box_max_y, box_max_z};

    logic signed [DATA_WIDTH:0]   dmin_reg [NUM_AXES];
    logic signed [DATA_WIDTH:0]   dmax_reg [NUM_AXES];
    logic signed [DATA_WIDTH-1:0] dir_reg  [NUM_AXES];
    rasi_side_t                   s1_reg;
    rasi_side_t                   s1_next;

    always_comb
    begin
        s1_next.valid    = in_valid;
        s1_next.par_miss = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            s1_next.dir_zero[a] = dir[a] == '0;
            s1_next.dir_pos[a]  = !dir[a][DATA_WIDTH-1] && dir[a] != '0;
            if (dir[a] == '0 && (org[a] < bmn[a] || org[a] > bmx[a]))
                s1_next.par_miss = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else if (en)
            s1_reg <= s1_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                dmin_reg[a] <= (DATA_WIDTH+1)'(bmn[a]) - (DATA_WIDTH+1)'(org[a]);
                dmax_reg[a] <= (DATA_WIDTH+1)'(bmx[a]) - (DATA_WIDTH+1)'(org[a]);
                dir_reg[a]  <= dir[a];
            end
        end
    end

    // dividers
    logic signed [QW-1:0] qmin [NUM_AXES];
    logic signed [QW-1:0] qmax [NUM_AXES];

    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++) begin : g_axis
            logic [DATA_WIDTH:0]   mag_min;
            logic [DATA_WIDTH:0]   mag_max;
            logic [DATA_WIDTH-1:0] mag_dir;
            logic                  dneg;

            assign mag_min = dmin_reg[g][DATA_WIDTH] ? -dmin_reg[g] : dmin_reg[g];
            assign mag_max = dmax_reg[g][DATA_WIDTH] ? -dmax_reg[g] : dmax_reg[g];
            assign mag_dir = dir_reg[g][DATA_WIDTH-1] ? -dir_reg[g] : dir_reg[g];
            assign dneg    = dir_reg[g][DATA_WIDTH-1];

            rasi_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DATA_WIDTH)) u_div_min (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .num   ({mag_min, {FRAC_BITS{1'b0}}}),
                .den   (mag_dir),
                .neg   (dmin_reg[g][DATA_WIDTH] ^ dneg),
                .quo   (qmin[g])
            );

            rasi_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DATA_WIDTH)) u_div_max (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .num   ({mag_max, {FRAC_BITS{1'b0}}}),
                .den   (mag_dir),
                .neg   (dmax_reg[g][DATA_WIDTH] ^ dneg),
                .quo   (qmax[g])
            );
        end
    endgenerate

    // flags beside the dividers
    rasi_side_t side_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                side_reg[i] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= s1_reg;
            for (int i = 1; i < LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // stage e: entry and exit per axis
    logic signed [QW-1:0] entry_reg [NUM_AXES];
    logic signed [QW-1:0] exit_reg  [NUM_AXES];
    rasi_side_t           se_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            se_reg <= '0;
        else if (en)
            se_reg <= side_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                entry_reg[a] <= (qmin[a] < qmax[a]) ? qmin[a] : qmax[a];
                exit_reg[a]  <= (qmin[a] < qmax[a]) ? qmax[a] : qmin[a];
            end
        end
    end

    // stage f: near and far
    logic signed [QW-1:0] near_next;
    logic signed [QW-1:0] far_next;
    logic                 found;
    logic signed [QW-1:0] near_reg;
    logic signed [QW-1:0] far_reg;
    logic signed [QW-1:0] entf_reg [NUM_AXES];
    rasi_side_t           sf_reg;

    always_comb
    begin
        near_next = '0;
        far_next  = '0;
        found     = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (!se_reg.dir_zero[a])
            begin
                if (!found || entry_reg[a] > near_next)
                    near_next = entry_reg[a];
                if (!found || exit_reg[a] < far_next)
                    far_next = exit_reg[a];
                found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sf_reg <= '0;
        else if (en)
            sf_reg <= se_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg <= near_next;
            far_reg  <= far_next;
            entf_reg <= entry_reg;
        end
    end

    // stage g: decision, saturation, normal
    logic                  all_par;
    logic signed [QW-1:0]  lo_bound;
    logic                  miss;
    logic signed [QW-1:0]  t_sat;
    axis_t                 axis_sel;
    logic                  hit_reg;
    logic [DATA_WIDTH-1:0] t_near_reg;
    axis_t                 axis_reg;
    logic                  nneg_reg;

    always_comb
    begin
        all_par  = &sf_reg.dir_zero;
        lo_bound = near_reg[QW-1] ? '0 : near_reg;
        miss     = sf_reg.par_miss || (!all_par && far_reg < lo_bound);
        if (all_par || near_reg < T_MIN)
            t_sat = T_MIN;
        else if (near_reg > T_MAX)
            t_sat = T_MAX;
        else
            t_sat = near_reg;
        axis_sel = AXIS_X;
        if (!sf_reg.dir_zero[2] && entf_reg[2] == near_reg)
            axis_sel = AXIS_Z;
        if (!sf_reg.dir_zero[1] && entf_reg[1] == near_reg)
            axis_sel = AXIS_Y;
        if (!sf_reg.dir_zero[0] && entf_reg[0] == near_reg)
            axis_sel = AXIS_X;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= sf_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg    <= !miss;
            t_near_reg <= miss ? '0 : t_sat[DATA_WIDTH-1:0];
            axis_reg   <= miss ? AXIS_X : axis_sel;
            nneg_reg   <= miss ? 1'b0 : sf_reg.dir_pos[axis_sel];
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign t_near          = signed'(t_near_reg);
    assign normal_axis     = axis_reg;
    assign normal_negative = nneg_reg;

endmodule

[tb/sv/tb_ray_aabb_slab_intersect_unit.sv]
// testbench for ray_aabb_slab_intersect_unit: directed and random ray/box items,
// results checked in order against a built-in slab test predictor
// depends on rasi_pkg and the unit rtl

module tb_ray_aabb_slab_intersect_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import rasi_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam longint NEG_INF = 64'sh8000_0000_0000_0000;
    localparam longint POS_INF = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int LIMIT = 400000;

    typedef struct {
        logic signed [DW-1:0] org [3];
        logic signed [DW-1:0] dir [3];
        logic signed [DW-1:0] bmin [3];
        logic signed [DW-1:0] bmax [3];
    } ray_box_t;

    typedef struct {
        logic                 hit;
        logic signed [DW-1:0] t_near;
        axis_t                axis;
        logic                 neg;
    } hit_rec_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [DW-1:0] origin_x = 0, origin_y = 0, origin_z = 0;
    logic signed [DW-1:0] dir_x = 0, dir_y = 0, dir_z = 0;
    logic signed [DW-1:0] box_min_x = 0, box_min_y = 0, box_min_z = 0;
    logic signed [DW-1:0] box_max_x = 0, box_max_y = 0, box_max_z = 0;
    logic out_valid;
    logic out_ready = 0;
    logic hit;
    logic signed [DW-1:0] t_near;
    axis_t normal_axis;
    logic normal_negative;

    ray_box_t pending_rays [$];
    hit_rec_t expected_hits [$];
    int errors = 0;
    int cycles = 0;
    bit stim_done = 0;
    int in_gap = 0;
    int out_gap = 0;

    ray_aabb_slab_intersect_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    function automatic longint slab_dist(longint corner, longint org, longint d);
        return ((corner - org) * (64'sd1 <<< FB)) / d;
    endfunction

    function automatic hit_rec_t slab_test(ray_box_t r);
        hit_rec_t res;
        longint entry [3];
        longint t0, t1, near_t, far_t, lo_b, tmax, tmin;
        bit miss;
        int ax;
        near_t = NEG_INF;
        far_t = POS_INF;
        miss = 0;
        for (int a = 0; a < 3; a++)
        begin
            longint ex;
            if (r.dir[a] == 0)
            begin
                entry[a] = NEG_INF;
                ex = POS_INF;
                if (r.org[a] < r.bmin[a] || r.org[a] > r.bmax[a])
                    miss = 1;
            end
            else
            begin
                t0 = slab_dist(r.bmin[a], r.org[a], r.dir[a]);
                t1 = slab_dist(r.bmax[a], r.org[a], r.dir[a]);
                entry[a] = (t0 < t1) ? t0 : t1;
                ex = (t0 < t1) ? t1 : t0;
            end
            if (entry[a] > near_t)
                near_t = entry[a];
            if (ex < far_t)
                far_t = ex;
        end
        lo_b = (near_t > 0) ? near_t : 0;
        if (far_t < lo_b)
            miss = 1;
        res = '{hit: 0, t_near: 0, axis: AXIS_X, neg: 0};
        if (!miss)
        begin
            tmax = (64'sd1 <<< (DW - 1)) - 1;
            tmin = -tmax - 1;
            res.hit = 1;
            res.t_near = DW'((near_t > tmax) ? tmax : (near_t < tmin) ? tmin : near_t);
            ax = (entry[0] == near_t) ? 0 : (entry[1] == near_t) ? 1 : 2;
            res.axis = (ax == 0) ? AXIS_X : (ax == 1) ? AXIS_Y : AXIS_Z;
            res.neg = (r.dir[ax] > 0);
        end
        return res;
    endfunction

    function automatic logic signed [DW-1:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 20 << FB)) - (10 << FB);
            default: return $signed($urandom_range(0, 8)) - 4;
        endcase
    endfunction

    function automatic ray_box_t random_ray();
        ray_box_t r;
        int mode;
        logic signed [DW-1:0] p, q;
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode < 9) ? 1 : 2;
        for (int a = 0; a < 3; a++)
        begin
            r.org[a] = rnd_coord(mode);
            case ($urandom_range(0, 9))
                0: r.dir[a] = 0;
                1: r.dir[a] = $urandom;
                2: r.dir[a] = $signed($urandom_range(0, 6)) - 3;
                default: r.dir[a] = $signed($urandom_range(0, 4 << FB)) - (2 << FB);
            endcase
            p = rnd_coord(mode);
            q = rnd_coord(mode);
            // mostly ordered corners, some swapped
            if ($urandom_range(0, 9) != 0 && p > q)
            begin
                r.bmin[a] = q;
                r.bmax[a] = p;
            end
            else
            begin
                r.bmin[a] = p;
                r.bmax[a] = q;
            end
            if ($urandom_range(0, 7) == 0)
                r.org[a] = r.bmin[a];
        end
        return r;
    endfunction

    function automatic ray_box_t make_ray(logic signed [DW-1:0] o, logic signed [DW-1:0] d,
                                          logic signed [DW-1:0] lo, logic signed [DW-1:0] hi);
        ray_box_t r;
        for (int a = 0; a < 3; a++)
        begin
            r.org[a] = o;
            r.dir[a] = d;
            r.bmin[a] = lo;
            r.bmax[a] = hi;
        end
        return r;
    endfunction

    task automatic r_drive(ray_box_t r);
        origin_x <= r.org[0]; origin_y <= r.org[1]; origin_z <= r.org[2];
        dir_x <= r.dir[0]; dir_y <= r.dir[1]; dir_z <= r.dir[2];
        box_min_x <= r.bmin[0]; box_min_y <= r.bmin[1]; box_min_z <= r.bmin[2];
        box_max_x <= r.bmax[0]; box_max_y <= r.bmax[1]; box_max_z <= r.bmax[2];
    endtask

    initial
    begin
        ray_box_t r;
        localparam logic signed [DW-1:0] ONE = 1 << FB;
        localparam logic signed [DW-1:0] MX = {1'b0, {(DW-1){1'b1}}};
        localparam logic signed [DW-1:0] MN = {1'b1, {(DW-1){1'b0}}};
        // front hit on x
        r = make_ray(0, 0, -ONE, ONE);
        r.org[0] = -5 * ONE; r.dir[0] = ONE;
        pending_rays.push_back(r);
        // negative direction, y face
        r = make_ray(0, 0, -ONE, ONE);
        r.org[1] = 5 * ONE; r.dir[1] = -ONE;
        pending_rays.push_back(r);
        // z face
        r = make_ray(0, 0, -ONE, ONE);
        r.org[2] = -3 * ONE; r.dir[2] = 2 * ONE;
        pending_rays.push_back(r);
        // all parallel, inside and on bounds
        pending_rays.push_back(make_ray(0, 0, -ONE, ONE));
        pending_rays.push_back(make_ray(ONE, 0, -ONE, ONE));
        // parallel outside
        pending_rays.push_back(make_ray(2 * ONE, 0, -ONE, ONE));
        // swapped corners, parallel then moving
        pending_rays.push_back(make_ray(0, 0, ONE, -ONE));
        pending_rays.push_back(make_ray(0, ONE, ONE, -ONE));
        // origin inside, moving: negative t
        pending_rays.push_back(make_ray(0, ONE, -ONE, ONE));
        // box behind
        pending_rays.push_back(make_ray(5 * ONE, ONE, -ONE, ONE));
        // diagonal equal entries
        pending_rays.push_back(make_ray(-2 * ONE, ONE, -ONE, ONE));
        // field extremes, saturation
        pending_rays.push_back(make_ray(MN, 1, 0, MX));
        pending_rays.push_back(make_ray(MN, -1, MN, MX));
        pending_rays.push_back(make_ray(MX, MN, MN, MX));
        pending_rays.push_back(make_ray(MN, MX, MX, MX));
        pending_rays.push_back(make_ray(-1, 1, MN, MN));
        pending_rays.push_back(make_ray(MX, -1, MN, MN));
        pending_rays.push_back(make_ray(MX, 0, MX, MX));
        pending_rays.push_back(make_ray(MN, 0, MN, MN));
        pending_rays.push_back(make_ray(-1, -1, -1, -1));
        for (int i = 0; i < 1630; i++)
            pending_rays.push_back(random_ray());
        stim_done = 1;
    end

    // driver
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles < 7)
            rst_n <= 0;
        else
        begin
            rst_n <= 1;
            if (in_valid && in_ready)
            begin
                expected_hits.push_back(slab_test(pending_rays.pop_front()));
                in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            end
            if (!(in_valid && !in_ready))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 0;
                end
                else if (pending_rays.size() > 0 && rst_n && !(in_valid && in_ready &&
                         pending_rays.size() == 0))
                begin
                    r_drive(pending_rays[0]);
                    in_valid <= 1;
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        hit_rec_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected item hit=%0d t_near=%0d", $realtime, hit, t_near);
                    errors++;
                end
                else
                begin
                    e = expected_hits.pop_front();
                    if (hit !== e.hit)
                    begin
                        $display("%0t: hit expected %0d actual %0d", $realtime, e.hit, hit);
                        errors++;
                    end
                    if (t_near !== e.t_near)
                    begin
                        $display("%0t: t_near expected %0d actual %0d", $realtime, e.t_near,
                                 t_near);
                        errors++;
                    end
                    if (normal_axis !== e.axis)
                    begin
                        $display("%0t: normal_axis expected %0d actual %0d", $realtime, e.axis,
                                 normal_axis);
                        errors++;
                    end
                    if (normal_negative !== e.neg)
                    begin
                        $display("%0t: normal_negative expected %0d actual %0d", $realtime,
                                 e.neg, normal_negative);
                        errors++;
                    end
                end
                out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 0;
            end
            else
                out_ready <= 1;
        end
    end

    initial
    begin
        wait (stim_done);
        wait (rst_n);
        while ((pending_rays.size() > 0 || in_valid || expected_hits.size() > 0)
               && cycles < LIMIT)
            @(posedge clk);
        repeat (DW + FB + 20) @(posedge clk);
        if (cycles >= LIMIT)
            $display("Simulation FAILED");
        else if (errors == 0 && expected_hits.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[ray_aabb_slab_intersect_unit.f]
hw/rtl/rasi_pkg.sv
hw/rtl/rasi_div.sv
hw/rtl/ray_aabb_slab_intersect_unit.sv
tb/sv/tb_ray_aabb_slab_intersect_unit.sv
